// ===== rtl/tbw_pkg.sv =====
// shared types and constants for the triangle barycentric weight block
`default_nettype none
package tbw_pkg;

   localparam int CRD_W  = 16;          // coordinate width, signed Q12.4
   localparam int DIF_W  = CRD_W + 1;   // coordinate difference
   localparam int PRD_W  = 2 * DIF_W;   // one partial product
   localparam int CRS_W  = PRD_W + 1;   // cross product, signed
   localparam int MAG_W  = CRS_W;       // cross product magnitude
   localparam int FRAC_W = 14;          // weight fraction bits
   localparam int WGT_W  = 16;          // weight width, unsigned Q2.14
   localparam int DVD_W  = MAG_W + FRAC_W + 1;
   localparam int NCRS   = 7;           // cross products per item

   // cross product slots
   localparam int X_EAB  = 0;
   localparam int X_ECA  = 1;
   localparam int X_EBC  = 2;
   localparam int X_AREA = 3;
   localparam int X_NA   = 4;
   localparam int X_NB   = 5;
   localparam int X_NC   = 6;

   localparam logic [WGT_W-1:0] WGT_MAX = '1;

   typedef struct packed {
      logic signed [CRD_W-1:0] point_x;
      logic signed [CRD_W-1:0] point_y;
      logic signed [CRD_W-1:0] vert_a_x;
      logic signed [CRD_W-1:0] vert_a_y;
      logic signed [CRD_W-1:0] vert_b_x;
      logic signed [CRD_W-1:0] vert_b_y;
      logic signed [CRD_W-1:0] vert_c_x;
      logic signed [CRD_W-1:0] vert_c_y;
   } req_type;

   typedef struct packed {
      logic             inside_res;
      logic             degenerate;
      logic [WGT_W-1:0] weight_a;
      logic [WGT_W-1:0] weight_b;
      logic [WGT_W-1:0] weight_c;
   } rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [WGT_W-1:0] low;
      logic [WGT_W-1:0] quo;
      logic             sat;
   } div_lane_type;

   typedef struct packed {
      logic [MAG_W-1:0]       area;
      logic                   inside_flag;
      logic                   degen;
      div_lane_type [2:0]     lane;
   } div_stage_type;

endpackage
`default_nettype wire

// ===== rtl/triangle_barycentric_weights.sv =====
// triangle edge test and barycentric weight pipeline, top level
//
// usage
//   req_ channel carries one pixel point and three vertices (signed Q12.4) per
//   transfer; rsp_ channel returns the inside flag, the degenerate flag and
//   three unsigned Q2.14 weights, one result per request, in order
//   throughput is one item per cycle while the result side does not stall
//   stages: differences, products, cross products, magnitudes and flags,
//   divide setup with saturation check, then 16 restoring divide steps that
//   each produce one quotient bit for all three weights in parallel
//   the sixteen divide steps make up most of the latency
//   reset clears every stage valid bit; payload registers are not reset
//   when the receiver holds rsp_ready low with a result waiting, the whole
//   pipeline freezes and req_ready drops; nothing is lost or repeated
//   req_ready is high whenever the output holds no result or it is taken
//   a zero-area triangle returns degenerate set and zero weights
`default_nettype none
module triangle_barycentric_weights
   import tbw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int NSTEP = WGT_W;   // divide steps

   // global advance: pipeline moves unless a finished result is stalled
   logic adv;

   // stage 1: coordinate differences
   logic                    s1_vld_ff;
   logic signed [DIF_W-1:0] ux_ff [NCRS];
   logic signed [DIF_W-1:0] uy_ff [NCRS];
   logic signed [DIF_W-1:0] vx_ff [NCRS];
   logic signed [DIF_W-1:0] vy_ff [NCRS];
   logic signed [DIF_W-1:0] ux_in [NCRS];
   logic signed [DIF_W-1:0] uy_in [NCRS];
   logic signed [DIF_W-1:0] vx_in [NCRS];
   logic signed [DIF_W-1:0] vy_in [NCRS];

   // stage 2: products
   logic                    s2_vld_ff;
   logic signed [PRD_W-1:0] pl_ff [NCRS];
   logic signed [PRD_W-1:0] pr_ff [NCRS];

   // stage 3: cross products
   logic                    s3_vld_ff;
   logic signed [CRS_W-1:0] crs_ff [NCRS];

   // stage 4: magnitudes and flags
   logic             s4_vld_ff;
   logic             inside_ff;
   logic             degen_ff;
   logic [MAG_W-1:0] area_ff;
   logic [MAG_W-1:0] num_ff [3];

   // divide pipeline, entry 0 is setup
   logic          dv_vld_ff [NSTEP+1];
   div_stage_type dv_ff     [NSTEP+1];
   div_stage_type dv_in     [NSTEP+1];

   assign adv       = !dv_vld_ff[NSTEP] || rsp_ready;
   assign req_ready = adv;

   function automatic logic signed [DIF_W-1:0] sub_c(
      input logic signed [CRD_W-1:0] a,
      input logic signed [CRD_W-1:0] b
   );
      return DIF_W'(a) - DIF_W'(b);
   endfunction

   // operand pairs: cross = ux*vy - uy*vx
   always_comb begin
      // edge ab: (b-a) x (p-a)
      ux_in[X_EAB] = sub_c(req_data.vert_b_x, req_data.vert_a_x);
      uy_in[X_EAB] = sub_c(req_data.vert_b_y, req_data.vert_a_y);
      vx_in[X_EAB] = sub_c(req_data.point_x, req_data.vert_a_x);
      vy_in[X_EAB] = sub_c(req_data.point_y, req_data.vert_a_y);
      // edge ca: (a-c) x (p-c)
      ux_in[X_ECA] = sub_c(req_data.vert_a_x, req_data.vert_c_x);
      uy_in[X_ECA] = sub_c(req_data.vert_a_y, req_data.vert_c_y);
      vx_in[X_ECA] = sub_c(req_data.point_x, req_data.vert_c_x);
      vy_in[X_ECA] = sub_c(req_data.point_y, req_data.vert_c_y);
      // edge bc: (c-b) x (p-b)
      ux_in[X_EBC] = sub_c(req_data.vert_c_x, req_data.vert_b_x);
      uy_in[X_EBC] = sub_c(req_data.vert_c_y, req_data.vert_b_y);
      vx_in[X_EBC] = sub_c(req_data.point_x, req_data.vert_b_x);
      vy_in[X_EBC] = sub_c(req_data.point_y, req_data.vert_b_y);
      // doubled area: (b-a) x (c-a)
      ux_in[X_AREA] = sub_c(req_data.vert_b_x, req_data.vert_a_x);
      uy_in[X_AREA] = sub_c(req_data.vert_b_y, req_data.vert_a_y);
      vx_in[X_AREA] = sub_c(req_data.vert_c_x, req_data.vert_a_x);
      vy_in[X_AREA] = sub_c(req_data.vert_c_y, req_data.vert_a_y);
      // sub-triangles, signs drop out in the magnitude
      ux_in[X_NA] = sub_c(req_data.point_x, req_data.vert_b_x);
      uy_in[X_NA] = sub_c(req_data.point_y, req_data.vert_b_y);
      vx_in[X_NA] = sub_c(req_data.point_x, req_data.vert_c_x);
      vy_in[X_NA] = sub_c(req_data.point_y, req_data.vert_c_y);
      ux_in[X_NB] = sub_c(req_data.point_x, req_data.vert_c_x);
      uy_in[X_NB] = sub_c(req_data.point_y, req_data.vert_c_y);
      vx_in[X_NB] = sub_c(req_data.point_x, req_data.vert_a_x);
      vy_in[X_NB] = sub_c(req_data.point_y, req_data.vert_a_y);
      ux_in[X_NC] = sub_c(req_data.point_x, req_data.vert_b_x);
      uy_in[X_NC] = sub_c(req_data.point_y, req_data.vert_b_y);
      vx_in[X_NC] = sub_c(req_data.point_x, req_data.vert_a_x);
      vy_in[X_NC] = sub_c(req_data.point_y, req_data.vert_a_y);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         for (int i = 0; i <= NSTEP; i++) dv_vld_ff[i] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         dv_vld_ff[0] <= s4_vld_ff;
         for (int i = 1; i <= NSTEP; i++) dv_vld_ff[i] <= dv_vld_ff[i-1];
      end
   end

   // arithmetic front end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NCRS; k++) begin
            ux_ff[k]  <= ux_in[k];
            uy_ff[k]  <= uy_in[k];
            vx_ff[k]  <= vx_in[k];
            vy_ff[k]  <= vy_in[k];
            pl_ff[k]  <= ux_ff[k] * vy_ff[k];
            pr_ff[k]  <= uy_ff[k] * vx_ff[k];
            crs_ff[k] <= CRS_W'(pl_ff[k]) - CRS_W'(pr_ff[k]);
         end
         inside_ff <= !crs_ff[X_EAB][CRS_W-1] && !crs_ff[X_ECA][CRS_W-1]
                      && !crs_ff[X_EBC][CRS_W-1];
         degen_ff  <= (crs_ff[X_AREA] == '0);
         area_ff   <= crs_ff[X_AREA][CRS_W-1] ? MAG_W'(-crs_ff[X_AREA])
                                              : MAG_W'(crs_ff[X_AREA]);
         for (int j = 0; j < 3; j++) begin
            num_ff[j] <= crs_ff[X_NA+j][CRS_W-1] ? MAG_W'(-crs_ff[X_NA+j])
                                                 : MAG_W'(crs_ff[X_NA+j]);
         end
      end
   end

   // divide setup: dividend = num * 2^14 + area/2, saturate if q > 65535
   always_comb begin
      logic [DVD_W-1:0] dvd;
      dv_in[0].area        = area_ff;
      dv_in[0].inside_flag = inside_ff;
      dv_in[0].degen       = degen_ff;
      for (int j = 0; j < 3; j++) begin
         dvd = {1'b0, num_ff[j], {FRAC_W{1'b0}}} + DVD_W'(area_ff >> 1);
         dv_in[0].lane[j].sat = ({1'b0, dvd} >= {area_ff, {WGT_W{1'b0}}});
         dv_in[0].lane[j].rem = MAG_W'(dvd[DVD_W-1:WGT_W]);
         dv_in[0].lane[j].low = dvd[WGT_W-1:0];
         dv_in[0].lane[j].quo = '0;
      end
   end

   // one restoring divide step per stage, all three lanes side by side
   for (genvar s = 1; s <= NSTEP; s++) begin : g_step
      always_comb begin
         logic [MAG_W:0] t;
         logic           ge;
         dv_in[s] = dv_ff[s-1];
         for (int j = 0; j < 3; j++) begin
            t  = {dv_ff[s-1].lane[j].rem, dv_ff[s-1].lane[j].low[NSTEP-s]};
            ge = (t >= {1'b0, dv_ff[s-1].area});
            dv_in[s].lane[j].rem = ge ? MAG_W'(t - {1'b0, dv_ff[s-1].area})
                                      : t[MAG_W-1:0];
            dv_in[s].lane[j].quo = {dv_ff[s-1].lane[j].quo[WGT_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= NSTEP; i++) dv_ff[i] <= dv_in[i];
      end
   end

   // result formatting
   function automatic logic [WGT_W-1:0] fmt_w(
      input logic         degen,
      input div_lane_type ln
   );
      if (degen) return '0;
      if (ln.sat) return WGT_MAX;
      return ln.quo;
   endfunction

   assign rsp_valid           = dv_vld_ff[NSTEP];
   assign rsp_data.inside_res = dv_ff[NSTEP].inside_flag;
   assign rsp_data.degenerate = dv_ff[NSTEP].degen;
   assign rsp_data.weight_a   = fmt_w(dv_ff[NSTEP].degen, dv_ff[NSTEP].lane[0]);
   assign rsp_data.weight_b   = fmt_w(dv_ff[NSTEP].degen, dv_ff[NSTEP].lane[1]);
   assign rsp_data.weight_c   = fmt_w(dv_ff[NSTEP].degen, dv_ff[NSTEP].lane[2]);

endmodule
`default_nettype wire

// ===== rtl/tbw_checker.sv =====
// port-level checks for the triangle barycentric weight block, with bind
`default_nettype none
module tbw_port_assertions
   import tbw_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // degenerate triangles carry zero weights
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.weight_a == '0 && rsp_data.weight_b == '0
         && rsp_data.weight_c == '0)
      else $error("degenerate result with nonzero weight");

   // input side only stalls when a result is waiting
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

endmodule

bind triangle_barycentric_weights tbw_port_assertions u_tbw_port_assertions (.*);
`default_nettype wire

// ===== tb/sv/tbw_checker.sv =====
// checker for the barycentric weight block: predicts each result and compares it
`timescale 1ns / 100ps
`default_nettype none
module tbw_checker
   import tbw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   rsp_type weights_due[$];

   function automatic longint edge_cross(longint ux, longint uy, longint vx, longint vy);
      return ux * vy - uy * vx;
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [WGT_W-1:0] q214_ratio(longint num, longint area);
      longint q;
      q = ((num <<< FRAC_W) + (area >>> 1)) / area;
      return q > 65535 ? WGT_MAX : q[WGT_W-1:0];
   endfunction

   function automatic rsp_type predict_weights(req_type r);
      longint px, py, ax, ay, bx, by, cx, cy, area;
      rsp_type o;
      px = r.point_x;  py = r.point_y;
      ax = r.vert_a_x; ay = r.vert_a_y;
      bx = r.vert_b_x; by = r.vert_b_y;
      cx = r.vert_c_x; cy = r.vert_c_y;
      o.inside_res = edge_cross(bx - ax, by - ay, px - ax, py - ay) >= 0
                  && edge_cross(ax - cx, ay - cy, px - cx, py - cy) >= 0
                  && edge_cross(cx - bx, cy - by, px - bx, py - by) >= 0;
      area = magnitude(edge_cross(bx - ax, by - ay, cx - ax, cy - ay));
      o.degenerate = (area == 0);
      o.weight_a = '0;
      o.weight_b = '0;
      o.weight_c = '0;
      if (area != 0) begin
         o.weight_a = q214_ratio(magnitude(edge_cross(bx - px, by - py, cx - px, cy - py)), area);
         o.weight_b = q214_ratio(magnitude(edge_cross(cx - px, cy - py, ax - px, ay - py)), area);
         o.weight_c = q214_ratio(magnitude(edge_cross(bx - px, by - py, ax - px, ay - py)), area);
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending_count = weights_due.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            weights_due.push_back(predict_weights(req_data));
         if (rsp_valid && rsp_ready) begin
            if (weights_due.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = weights_due.pop_front();
               if (rsp_data.inside_res != want.inside_res)
                  report_mismatch("inside_res", rsp_data.inside_res, want.inside_res);
               if (rsp_data.degenerate != want.degenerate)
                  report_mismatch("degenerate", rsp_data.degenerate, want.degenerate);
               if (rsp_data.weight_a != want.weight_a)
                  report_mismatch("weight_a", rsp_data.weight_a, want.weight_a);
               if (rsp_data.weight_b != want.weight_b)
                  report_mismatch("weight_b", rsp_data.weight_b, want.weight_b);
               if (rsp_data.weight_c != want.weight_c)
                  report_mismatch("weight_c", rsp_data.weight_c, want.weight_c);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench top: drives triangles into the weight block and gives the verdict
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import tbw_pkg::*;

   localparam int DIRECTED_N = 20;
   localparam int RANDOM_N   = 1250;
   localparam int DRAIN_WAIT = 40;
   localparam int CYCLE_CAP  = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   bit      long_hold = 1'b0;   // sender asks the receiver for one long stall
   bit      stim_done = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   triangle_barycentric_weights i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   tbw_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending_count
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic signed [CRD_W-1:0] any_coord();
      case ($urandom_range(0, 5))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         default: return CRD_W'($urandom);
      endcase
   endfunction

   // mostly a small ccw triangle with a nearby point, sometimes wild values
   function automatic req_type random_triangle();
      req_type r;
      int      ox, oy, span;
      if ($urandom_range(0, 9) < 2) begin
         r = {$urandom, $urandom, $urandom, $urandom};
         if ($urandom_range(0, 3) == 0) r.vert_a_x = any_coord();
         if ($urandom_range(0, 3) == 0) r.point_y  = any_coord();
         return r;
      end
      span = $urandom_range(0, 3) == 0 ? 16000 : $urandom_range(1, 600);
      ox = $signed($urandom_range(0, 32000)) - 16000;
      oy = $signed($urandom_range(0, 32000)) - 16000;
      r.vert_a_x = CRD_W'(ox);
      r.vert_a_y = CRD_W'(oy);
      r.vert_b_x = CRD_W'(ox + $urandom_range(0, span));
      r.vert_b_y = CRD_W'(oy + $signed($urandom_range(0, span / 2)));
      r.vert_c_x = CRD_W'(ox + $signed($urandom_range(0, span)) - span / 2);
      r.vert_c_y = CRD_W'(oy + $urandom_range(0, span));
      r.point_x  = CRD_W'(ox + $signed($urandom_range(0, 2 * span)) - span / 2);
      r.point_y  = CRD_W'(oy + $signed($urandom_range(0, 2 * span)) - span / 2);
      if ($urandom_range(0, 7) == 0) begin
         // collinear vertices
         r.vert_c_x = r.vert_b_x;
         r.vert_c_y = r.vert_b_y;
      end
      if ($urandom_range(0, 7) == 0) begin
         // swap to clockwise winding
         r.vert_b_x = r.vert_c_x;
         r.vert_b_y = r.vert_c_y;
         r.vert_c_x = CRD_W'(ox + $urandom_range(0, span));
         r.vert_c_y = CRD_W'(oy + $signed($urandom_range(0, span / 2)));
      end
      return r;
   endfunction

   function automatic req_type directed_triangle(int k);
      req_type r;
      r = '0;
      r.vert_b_x = 16'sd160;
      r.vert_c_y = 16'sd160;
      case (k)
         0: begin r.point_x = 16'sd32;  r.point_y = 16'sd32; end   // inside
         1: begin r.point_x = 16'sd0;   r.point_y = 16'sd0;  end   // on a vertex
         2: begin r.point_x = 16'sd80;  r.point_y = 16'sd0;  end   // on an edge
         3: begin r.point_x = -16'sd32; r.point_y = 16'sd16; end   // outside
         4: begin r.point_x = 16'sh7fff; r.point_y = 16'sh7fff; end // saturates
         5: begin r.vert_c_y = 16'sd0; end                          // zero area
         6: r = '0;                                                 // all points equal
         7: begin                                                   // clockwise
            r.vert_b_x = 16'sd0;   r.vert_b_y = 16'sd160;
            r.vert_c_x = 16'sd160; r.vert_c_y = 16'sd0;
            r.point_x  = 16'sd16;  r.point_y  = 16'sd16;
         end
         8: begin                                                   // largest triangle
            r.vert_a_x = 16'sh8000; r.vert_a_y = 16'sh8000;
            r.vert_b_x = 16'sh7fff; r.vert_b_y = 16'sh8000;
            r.vert_c_x = 16'sh8000; r.vert_c_y = 16'sh7fff;
            r.point_x  = 16'sh8000; r.point_y  = 16'sh7fff;
         end
         9: begin                                                   // far point, extremes
            r.vert_a_x = 16'sh7fff; r.vert_a_y = 16'sh7fff;
            r.vert_b_x = 16'sh7fff; r.vert_b_y = 16'sh7ffe;
            r.vert_c_x = 16'sh7ffe; r.vert_c_y = 16'sh7fff;
            r.point_x  = 16'sh8000; r.point_y  = 16'sh8000;
         end
         10: begin                                                  // all bits set
            r = {8{16'shffff}};
         end
         11: begin                                                  // odd area, rounding case
            r.vert_b_x = 16'sd3; r.vert_c_y = 16'sd1; r.point_x = 16'sd1;
         end
         default: r = random_triangle();
      endcase
      return r;
   endfunction

   // optional idle gap first, then offer the item until it is taken
   task automatic send_triangle(req_type r);
      int idle;
      idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
            long_hold = 1'b0;
         end
         hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int burst;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < DIRECTED_N; k++) send_triangle(directed_triangle(k));
      // pause until every expected transfer has come back
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int n = 0; n < RANDOM_N; n++) begin
         if (n == RANDOM_N / 3) begin
            // receiver stalls long while back-to-back items keep coming
            long_hold = 1'b1;
            for (burst = 0; burst < 60; burst++) begin
               req_valid <= 1'b1;
               req_data  <= random_triangle();
               do @(posedge clock); while (!req_ready);
            end
         end
         if (n == RANDOM_N / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         if (n % 200 < 40) begin
            // no-gap stretch
            req_valid <= 1'b1;
            req_data  <= random_triangle();
            do @(posedge clock); while (!req_ready);
         end else begin
            send_triangle(random_triangle());
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
